FILE: hdl/sokv_pkg.sv
// Shared types and constants for the set-once key/value table.
// Used by sokv_ctrl, sokv_dp and set_once_key_value_table; depends on nothing.
`default_nettype none

package sokv_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int KEY_W         = 64;
	localparam int VAL_W         = 64;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_SET = 1'b1;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [TABLE_ENTRIES-1:0] row_t;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic             hit;
		logic             table_full;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_LOOK,
		ST_DEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;     // capture request
		logic cmp;     // register match and free vectors
		logic look;    // encode indexes, read value memory
		logic commit;  // update table, load result register
	} cmd_t;

endpackage

`default_nettype wire

FILE: hdl/sokv_ctrl.sv
// Controller state machine for the set-once key/value table.
// Depends on sokv_pkg; drives the datapath through sokv_pkg::cmd_t.
`default_nettype none

module sokv_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sokv_pkg::cmd_t     cmd
);

	sokv_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sokv_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			sokv_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = sokv_pkg::ST_CMP;
				end
			end
			sokv_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sokv_pkg::ST_LOOK;
			end
			sokv_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sokv_pkg::ST_DEC;
			end
			sokv_pkg::ST_DEC: begin
				// wait until the result register is free or being emptied
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.commit = 1'b1;
					state_d    = sokv_pkg::ST_IDLE;
				end
			end
			default: state_d = sokv_pkg::ST_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == sokv_pkg::ST_DEC))
		else $error("result appeared without a commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid || !rsp_stall))
		else $error("commit would overwrite a stalled result");

endmodule

`default_nettype wire

FILE: hdl/sokv_dp.sv
// Datapath for the set-once key/value table: key CAM, valid marks, value memory,
// index encoders and result register. Depends on sokv_pkg.
`default_nettype none

module sokv_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sokv_pkg::req_t req,
	input  wire sokv_pkg::cmd_t cmd,
	output sokv_pkg::rsp_t      rsp
);

	sokv_pkg::req_t              req_q;
	sokv_pkg::row_t              valid_q;
	logic [sokv_pkg::KEY_W-1:0]  key_q [sokv_pkg::TABLE_ENTRIES];
	logic [sokv_pkg::VAL_W-1:0]  value_mem [sokv_pkg::TABLE_ENTRIES];

	sokv_pkg::row_t              match_q, free_q, match_d, free_oh;
	sokv_pkg::idx_t              match_idx, free_idx;
	sokv_pkg::idx_t              match_idx_q, free_idx_q;
	logic                        found_q, have_free_q;
	logic [sokv_pkg::VAL_W-1:0]  rd_q;

	logic                        mem_we, ins_we;
	sokv_pkg::idx_t              mem_waddr;
	sokv_pkg::rsp_t              rsp_d, rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req;
		end
	end

	// parallel key compare against every valid entry
	always_comb begin
		for (int i = 0; i < sokv_pkg::TABLE_ENTRIES; i++) begin
			match_d[i] = valid_q[i] && (key_q[i] == req_q.key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			match_q <= match_d;
			free_q  <= ~valid_q;
		end
	end

	// lowest free entry isolated as a one-hot word
	assign free_oh = free_q & (~free_q + sokv_pkg::row_t'(1));

	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = 0; i < sokv_pkg::TABLE_ENTRIES; i++) begin
			if (match_q[i]) begin
				match_idx = match_idx | sokv_pkg::idx_t'(i);
			end
			if (free_oh[i]) begin
				free_idx = free_idx | sokv_pkg::idx_t'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			match_idx_q <= match_idx;
			free_idx_q  <= free_idx;
			found_q     <= |match_q;
			have_free_q <= |free_q;
		end
	end

	// decide result and table update
	always_comb begin
		rsp_d     = '0;
		mem_we    = 1'b0;
		ins_we    = 1'b0;
		mem_waddr = match_idx_q;
		rsp_d.hit = found_q;
		if (req_q.req_type == sokv_pkg::REQ_GET) begin
			if (found_q) begin
				rsp_d.result_value = rd_q;
			end
		end else if (found_q) begin
			if (rd_q != '0) begin
				rsp_d.result_value = rd_q;
			end else begin
				mem_we             = cmd.commit;
				rsp_d.result_value = req_q.value;
			end
		end else if (have_free_q) begin
			mem_we             = cmd.commit;
			ins_we             = cmd.commit;
			mem_waddr          = free_idx_q;
			rsp_d.result_value = req_q.value;
		end else begin
			rsp_d.table_full = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			rd_q <= value_mem[match_idx];
		end
		if (mem_we) begin
			value_mem[mem_waddr] <= req_q.value;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_we) begin
			key_q[free_idx_q] <= req_q.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ins_we) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look |-> $onehot0(match_q))
		else $error("key present in more than one entry");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (!rsp_q.table_full || (!rsp_q.hit && rsp_q.result_value == '0)))
		else $error("full result carries a hit or a value");

	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		ins_we |-> !valid_q[free_idx_q])
		else $error("insert into an occupied entry");

endmodule

`default_nettype wire

FILE: hdl/set_once_key_value_table.sv
// Set-once key/value table: 64-bit keys to 64-bit values, get and set-default.
// Steps after the accept edge: compare, encode/read, commit; commit waits while a
// stalled receiver holds the previous result. One item at a time, taken in IDLE; the
// value memory has one read and one write port, read once and written at most once per item.
// Reset: arst_n clears all valid marks at once; keys and values stay unreset.
// Depends on sokv_pkg, sokv_ctrl and sokv_dp.
`default_nettype none

module set_once_key_value_table (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// request channel
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire sokv_pkg::req_t req,
	// result channel
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output sokv_pkg::rsp_t      rsp
);

	// Command bundle from controller to datapath. The controller walks
	// IDLE -> CMP -> LOOK -> DEC for every item:
	//   IDLE: request captured on the accept edge
	//   CMP : key compared against all entries, match and free vectors registered
	//   LOOK: match/free indexes encoded, stored value read from the value memory
	//   DEC : table updated and result register loaded; this step waits while a
	//         previous result is still held by a stalled receiver
	// A new request is taken again in IDLE while the last result may still wait.
	sokv_pkg::cmd_t cmd;

	sokv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Datapath: the keys sit in flops for the parallel compare, the values in
	// a memory read once per item at the matching entry.
	sokv_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
